[rtl/cmdhist_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cmdhist_pkg;

    localparam int HISTORY_DEPTH = 8;
    localparam int LINE_BYTES    = 64;

    localparam int SLOT_W      = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int COUNT_W     = $clog2(HISTORY_DEPTH + 1);
    localparam int LEN_W       = $clog2(LINE_BYTES + 1);
    localparam int IDX_W       = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int LINE_SLOTS  = 2 ** IDX_W;
    localparam int STORE_DEPTH = HISTORY_DEPTH * LINE_SLOTS;
    localparam int STORE_AW    = SLOT_W + IDX_W;

    typedef enum logic [1:0] {
        REQ_PUSH  = 2'd0,
        REQ_OLDER = 2'd1,
        REQ_NEWER = 2'd2,
        REQ_CLEAR = 2'd3
    } req_t;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic       line_empty;
        logic       byte_last;
    } in_item_t;

    typedef struct packed {
        logic       status;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       result_last;
    } out_item_t;

    typedef enum logic [1:0] {
        PTR_NONE  = 2'd0,
        PTR_PUSH  = 2'd1,
        PTR_POP   = 2'd2,
        PTR_CLEAR = 2'd3
    } ptr_op_t;

    typedef enum logic [2:0] {
        POS_KEEP = 3'd0,
        POS_ZERO = 3'd1,
        POS_ONE  = 3'd2,
        POS_INC  = 3'd3,
        POS_DEC  = 3'd4
    } pos_op_t;

    typedef struct packed {
        logic    take;
        ptr_op_t ptr_op;
        pos_op_t pos_op;
        logic    browse_set;
        logic    browse_clr;
        logic    cnt_clear;
        logic    copy_run;
        logic    line_first;
        logic    line_next;
        logic    load_status;
        logic    status_val;
        logic    load_byte;
        logic    len_clear;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       enabled;
        logic       count_zero;
        logic       browsing;
        logic       pos_zero;
        logic       pos_adv;
        logic       len_zero;
        logic       copy_done;
        logic       sel_len_zero;
        logic       line_end;
        logic       out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/cmdhist_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module cmdhist_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/cmdhist_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module cmdhist_ctrl
    import cmdhist_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic       in_last,
    output logic            in_stall,
    input  wire dp_status_t sts,
    output dp_cmd_t         cmd
);

    typedef enum logic [5:0] {
        ST_IDLE       = 6'b000001,
        ST_DECIDE     = 6'b000010,
        ST_COPY       = 6'b000100,
        ST_LINE_START = 6'b001000,
        ST_LINE_SEND  = 6'b010000,
        ST_STATUS     = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   line_reg, line_next;
    logic   stval_reg, stval_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            line_reg  <= 1'b0;
            stval_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            line_reg  <= line_next;
            stval_reg <= stval_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        logic do_copy;
        logic do_line;
        state_next     = state_reg;
        line_next      = line_reg;
        stval_next     = stval_reg;
        do_copy        = 1'b0;
        do_line        = 1'b0;
        cmd            = '0;
        cmd.ptr_op     = PTR_NONE;
        cmd.pos_op     = POS_KEEP;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.take = 1'b1;
                    if (in_last)
                    begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                cmd.cnt_clear = 1'b1;
                stval_next    = 1'b0;
                if (!sts.enabled)
                begin
                    stval_next = 1'b1;
                end
                else
                begin
                    case (req_t'(sts.req))
                        REQ_PUSH:
                        begin
                            if (sts.browsing)
                            begin
                                if (!sts.len_zero)
                                begin
                                    do_copy = 1'b1;
                                end
                                else if (!sts.count_zero)
                                begin
                                    cmd.ptr_op = PTR_POP;
                                end
                                cmd.browse_clr = 1'b1;
                                cmd.pos_op     = POS_ZERO;
                            end
                            else if (!sts.len_zero)
                            begin
                                cmd.ptr_op = PTR_PUSH;
                                do_copy    = 1'b1;
                            end
                        end
                        REQ_OLDER:
                        begin
                            if (sts.count_zero)
                            begin
                                stval_next = 1'b1;
                            end
                            else if (sts.browsing)
                            begin
                                do_copy = sts.pos_zero;
                                do_line = 1'b1;
                                if (sts.pos_adv)
                                begin
                                    cmd.pos_op = POS_INC;
                                end
                            end
                            else
                            begin
                                cmd.ptr_op     = PTR_PUSH;
                                cmd.browse_set = 1'b1;
                                cmd.pos_op     = POS_ONE;
                                do_copy        = 1'b1;
                                do_line        = 1'b1;
                            end
                        end
                        REQ_NEWER:
                        begin
                            if (sts.count_zero || !sts.browsing)
                            begin
                                stval_next = 1'b1;
                            end
                            else
                            begin
                                do_line = 1'b1;
                                if (!sts.pos_zero)
                                begin
                                    cmd.pos_op = POS_DEC;
                                end
                            end
                        end
                        default:
                        begin
                            cmd.ptr_op     = PTR_CLEAR;
                            cmd.pos_op     = POS_ZERO;
                            cmd.browse_clr = 1'b1;
                        end
                    endcase
                end
                line_next = do_line;
                if (do_copy)
                begin
                    state_next = ST_COPY;
                end
                else if (do_line)
                begin
                    state_next = ST_LINE_START;
                end
                else
                begin
                    state_next = ST_STATUS;
                end
            end
            ST_COPY:
            begin
                cmd.copy_run = 1'b1;
                if (sts.copy_done)
                begin
                    state_next = line_reg ? ST_LINE_START : ST_STATUS;
                end
            end
            ST_LINE_START:
            begin
                if (sts.sel_len_zero)
                begin
                    stval_next = 1'b0;
                    state_next = ST_STATUS;
                end
                else
                begin
                    cmd.line_first = 1'b1;
                    state_next     = ST_LINE_SEND;
                end
            end
            ST_LINE_SEND:
            begin
                if (sts.out_free)
                begin
                    cmd.load_byte = 1'b1;
                    if (sts.line_end)
                    begin
                        cmd.len_clear = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        cmd.line_next = 1'b1;
                    end
                end
            end
            ST_STATUS:
            begin
                cmd.status_val = stval_reg;
                if (sts.out_free)
                begin
                    cmd.load_status = 1'b1;
                    cmd.len_clear   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/cmdhist_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module cmdhist_dp
    import cmdhist_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire in_item_t   in_data,
    output logic            out_valid,
    input  wire logic       out_stall,
    output out_item_t       out_data,
    input  wire dp_cmd_t    cmd,
    output dp_status_t      sts
);

    logic                enabled_reg;
    logic [SLOT_W-1:0]   head_reg, head_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0]   pos_reg, pos_next;
    logic                browsing_reg, browsing_next;
    logic [LEN_W-1:0]    in_len_reg, in_len_next;
    logic [1:0]          req_reg;
    logic [LEN_W-1:0]    cnt_reg, cnt_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pend_idx_reg;
    logic [SLOT_W-1:0]   sel_reg;
    logic [LEN_W-1:0]    sel_len_reg;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg;

    logic [LEN_W-1:0]    len_mem_reg [HISTORY_DEPTH];

    logic [SLOT_W:0]     sel_sum;
    logic [SLOT_W-1:0]   sel_slot;
    logic [LEN_W-1:0]    sel_len;
    logic                out_free;

    logic                in_wr_en;
    logic                in_rd_en;
    logic [7:0]          in_rd_data;
    logic                st_rd_en;
    logic [STORE_AW-1:0] st_rd_addr;
    logic [7:0]          st_rd_data;

    assign sel_sum  = {1'b0, head_reg} + {1'b0, pos_reg};
    assign sel_slot = (sel_sum >= (SLOT_W + 1)'(HISTORY_DEPTH))
                    ? SLOT_W'(sel_sum - (SLOT_W + 1)'(HISTORY_DEPTH))
                    : sel_sum[SLOT_W-1:0];
    assign sel_len  = len_mem_reg[sel_slot];
    assign out_free = !out_valid_reg || !out_stall;

    assign sts.req          = req_reg;
    assign sts.enabled      = enabled_reg;
    assign sts.count_zero   = (count_reg == '0);
    assign sts.browsing     = browsing_reg;
    assign sts.pos_zero     = (pos_reg == '0);
    assign sts.pos_adv      = ((COUNT_W'(pos_reg) + COUNT_W'(1)) < count_reg);
    assign sts.len_zero     = (in_len_reg == '0);
    assign sts.copy_done    = (cnt_reg == in_len_reg);
    assign sts.sel_len_zero = (sel_len == '0);
    assign sts.line_end     = (cnt_reg == sel_len_reg);
    assign sts.out_free     = out_free;

    assign in_wr_en = cmd.take && !in_data.line_empty
                   && (in_len_reg < LEN_W'(LINE_BYTES));
    assign in_rd_en = cmd.copy_run && (cnt_reg < in_len_reg);

    assign st_rd_en   = cmd.line_first || cmd.line_next;
    assign st_rd_addr = cmd.line_first ? {sel_slot, {IDX_W{1'b0}}}
                                       : {sel_reg, cnt_reg[IDX_W-1:0]};

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    cmdhist_ram #(
        .WIDTH (8),
        .DEPTH (LINE_SLOTS)
    ) u_input_ram (
        .clk     (clk),
        .wr_en   (in_wr_en),
        .wr_addr (in_len_reg[IDX_W-1:0]),
        .wr_data (in_data.data_byte),
        .rd_en   (in_rd_en),
        .rd_addr (cnt_reg[IDX_W-1:0]),
        .rd_data (in_rd_data)
    );

    cmdhist_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_store_ram (
        .clk     (clk),
        .wr_en   (pend_reg),
        .wr_addr ({head_reg, pend_idx_reg}),
        .wr_data (in_rd_data),
        .rd_en   (st_rd_en),
        .rd_addr (st_rd_addr),
        .rd_data (st_rd_data)
    );

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        browsing_next  = browsing_reg;
        in_len_next    = in_len_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        out_valid_next = out_valid_reg;

        case (cmd.ptr_op)
            PTR_PUSH:
            begin
                head_next = (head_reg == '0) ? SLOT_W'(HISTORY_DEPTH - 1)
                                             : head_reg - SLOT_W'(1);
                if (count_reg < COUNT_W'(HISTORY_DEPTH))
                begin
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            PTR_POP:
            begin
                head_next  = (head_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                       : head_reg + SLOT_W'(1);
                count_next = count_reg - COUNT_W'(1);
            end
            PTR_CLEAR:
            begin
                head_next  = '0;
                count_next = '0;
            end
            default:
            begin
            end
        endcase

        case (cmd.pos_op)
            POS_ZERO: pos_next = '0;
            POS_ONE:  pos_next = SLOT_W'(1);
            POS_INC:  pos_next = pos_reg + SLOT_W'(1);
            POS_DEC:  pos_next = pos_reg - SLOT_W'(1);
            default:  pos_next = pos_reg;
        endcase

        if (cmd.browse_set)
        begin
            browsing_next = 1'b1;
        end
        else if (cmd.browse_clr)
        begin
            browsing_next = 1'b0;
        end

        if (in_wr_en)
        begin
            in_len_next = in_len_reg + LEN_W'(1);
        end
        else if (cmd.len_clear)
        begin
            in_len_next = '0;
        end

        if (cmd.cnt_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.line_first)
        begin
            cnt_next = LEN_W'(1);
        end
        else if (in_rd_en || cmd.line_next)
        begin
            cnt_next = cnt_reg + LEN_W'(1);
        end

        if (in_rd_en)
        begin
            pend_next = 1'b1;
        end

        if (cmd.load_status || cmd.load_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            browsing_reg  <= 1'b0;
            in_len_reg    <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                enabled_reg <= cfg_wr_data;
            end
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            browsing_reg  <= browsing_next;
            in_len_reg    <= in_len_next;
            cnt_reg       <= cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            req_reg <= in_data.req_type;
        end
        if (in_rd_en)
        begin
            pend_idx_reg <= cnt_reg[IDX_W-1:0];
        end
        if (cmd.copy_run)
        begin
            len_mem_reg[head_reg] <= in_len_reg;
        end
        if (cmd.line_first)
        begin
            sel_reg     <= sel_slot;
            sel_len_reg <= sel_len;
        end
        if (cmd.load_status)
        begin
            out_data_reg.status      <= cmd.status_val;
            out_data_reg.out_byte    <= 8'h00;
            out_data_reg.byte_valid  <= 1'b0;
            out_data_reg.result_last <= 1'b1;
        end
        else if (cmd.load_byte)
        begin
            out_data_reg.status      <= 1'b0;
            out_data_reg.out_byte    <= st_rd_data;
            out_data_reg.byte_valid  <= 1'b1;
            out_data_reg.result_last <= (cnt_reg == sel_len_reg);
        end
    end

endmodule

`default_nettype wire

[rtl/command_line_history.sv]
// command line history buffer, newest line first, with a browse position
//
// input channel (in_valid / in_stall / in_data): one transaction per line
// byte; line_empty marks a transaction without a byte. the transaction with
// byte_last set carries the request (push, older, newer, clear).
// output channel (out_valid / out_stall / out_data): a push, clear or
// refused request answers one status transaction; older and newer answer
// one transaction per byte of the selected line, result_last on the final.
// cfg_wr_en / cfg_wr_data write history_enabled; write only while idle.
//
// bytes before the last one are taken one per cycle. after the last one
// the request is decided, the current line of L bytes is copied when it
// is saved, the selected line is looked up, then one result per cycle
// follows unless the receiver stalls; the byte copy writes and the line
// readout reads the single line store ram. in_stall is high
// from the last byte until the final result is loaded into the output
// register. a stalled receiver holds the output register and stops the
// readout. reset empties the history, ends browsing and clears
// history_enabled; the line store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module command_line_history
    import cmdhist_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     cfg_wr_en,
    input  wire logic     cfg_wr_data,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    cmdhist_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_last  (in_data.byte_last),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    cmdhist_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

`default_nettype wire
